>>> sv/tpc_pkg.sv
// shared types, constants and the arctangent table for the tangent-plane
// deprojection pipeline; no dependencies
`default_nettype none

package tpc_pkg;

   // default parameter values
   localparam int PIXEL_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 32;

   // fixed-point formats
   localparam int FRAC_BITS = 12;
   localparam int XY_W      = 64;
   localparam int ANG_W     = 34;
   localparam int NORM_BITS = 57;

   localparam logic [63:0]              DEG_PER_RAD = 64'd258037251265019618;
   localparam logic [17:0]              NEAR_LIMIT  = 18'd258037;
   localparam logic [37:0]              NEAR_SQ     = 38'd66583093369;
   localparam logic [31:0]              INV_GAIN    = 32'd2608131496;
   localparam logic signed [ANG_W-1:0]  QUARTER     = 34'sd1073741824;
   localparam logic signed [ANG_W-1:0]  HALF        = 34'sd2147483648;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 40;

   localparam logic [CSR_ADDR_W-1:0] REG_REF_PIXEL_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_REF_PIXEL_Y = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_REF_RA      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_REF_DEC     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_XX    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_XY    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_YX    = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE_YY    = 3'd7;

   typedef struct packed {
      logic signed [28:0] ref_pixel_x;
      logic signed [28:0] ref_pixel_y;
      logic        [31:0] ref_ra;
      logic signed [31:0] ref_dec;
      logic signed [39:0] scale_xx;
      logic signed [39:0] scale_xy;
      logic signed [39:0] scale_yx;
      logic signed [39:0] scale_yy;
   } tpc_cfg_type;

   typedef enum logic {
      CELL_ROTATE,
      CELL_VECTOR
   } tpc_mode_type;

   // arctangent of 2^-step as a binary angle, zero past the table
   function automatic logic [31:0] arc_angle(input int step);
      logic [31:0] a;
      case (step)
         0:  a = 32'h20000000;
         1:  a = 32'h12E4051E;
         2:  a = 32'h09FB385B;
         3:  a = 32'h051111D4;
         4:  a = 32'h028B0D43;
         5:  a = 32'h0145D7E1;
         6:  a = 32'h00A2F61E;
         7:  a = 32'h00517C55;
         8:  a = 32'h0028BE53;
         9:  a = 32'h00145F2F;
         10: a = 32'h000A2F98;
         11: a = 32'h000517CC;
         12: a = 32'h00028BE6;
         13: a = 32'h000145F3;
         14: a = 32'h0000A2FA;
         15: a = 32'h0000517D;
         16: a = 32'h000028BE;
         17: a = 32'h0000145F;
         18: a = 32'h00000A30;
         19: a = 32'h00000518;
         20: a = 32'h0000028C;
         21: a = 32'h00000146;
         22: a = 32'h000000A3;
         23: a = 32'h00000051;
         24: a = 32'h00000029;
         25: a = 32'h00000014;
         26: a = 32'h0000000A;
         27: a = 32'h00000005;
         28: a = 32'h00000003;
         29: a = 32'h00000001;
         30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

>>> sv/tpc_cordic_cell.sv
// one CORDIC micro-rotation step with its pipeline register, rotation or
// vectoring mode, carrying a sideband along; depends on tpc_pkg
`default_nettype none

module tpc_cordic_cell #(
   parameter int                    STEP   = 0,
   parameter tpc_pkg::tpc_mode_type MODE   = tpc_pkg::CELL_ROTATE,
   parameter int                    SIDE_W = 1
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_valid,
   input  wire logic signed [tpc_pkg::XY_W-1:0]  in_x,
   input  wire logic signed [tpc_pkg::XY_W-1:0]  in_y,
   input  wire logic signed [tpc_pkg::ANG_W-1:0] in_z,
   input  wire logic [SIDE_W-1:0]               in_side,
   output logic                                 out_valid,
   output logic signed [tpc_pkg::XY_W-1:0]       out_x,
   output logic signed [tpc_pkg::XY_W-1:0]       out_y,
   output logic signed [tpc_pkg::ANG_W-1:0]      out_z,
   output logic [SIDE_W-1:0]                    out_side
);
   import tpc_pkg::*;

   localparam logic signed [ANG_W-1:0] ARC = $signed({2'b00, arc_angle(STEP)});

   logic                     valid_ff;
   logic signed [XY_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0]  z_ff, z_in;
   logic [SIDE_W-1:0]        side_ff;
   logic signed [XY_W-1:0]   sx, sy;
   logic                     turn_neg;

   // direction: rotate drives the angle to zero, vectoring drives y to zero
   always_comb begin
      sx = in_x >>> STEP;
      sy = in_y >>> STEP;
      if (MODE == CELL_ROTATE) begin
         turn_neg = !in_z[ANG_W-1];
      end else begin
         turn_neg = in_y[XY_W-1];
      end
      if (turn_neg) begin
         x_in = in_x - sy;
         y_in = in_y + sx;
         z_in = in_z - ARC;
      end else begin
         x_in = in_x + sy;
         y_in = in_y - sx;
         z_in = in_z + ARC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

>>> sv/tpc_front.sv
// front end: pixel offsets, split 2x2 matrix multiply, small-offset test,
// normalizing shift and reference declination fold; depends on tpc_pkg
`default_nettype none

module tpc_front #(
   parameter int PIXEL_BITS = tpc_pkg::PIXEL_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire tpc_pkg::tpc_cfg_type             cfg,
   input  wire logic                             in_valid,
   input  wire logic [PIXEL_BITS-1:0]            pixel_x,
   input  wire logic [PIXEL_BITS-1:0]            pixel_y,
   output logic                                  out_valid,
   output logic signed [tpc_pkg::XY_W-1:0]        out_ke,
   output logic signed [tpc_pkg::XY_W-1:0]        out_vn,
   output logic signed [tpc_pkg::XY_W-1:0]        out_ve,
   output logic signed [tpc_pkg::ANG_W-1:0]       out_d0,
   output logic                                  out_near
);
   import tpc_pkg::*;

   localparam int OFF_W  = ((PIXEL_BITS + FRAC_BITS + 1 > 29) ?
                            PIXEL_BITS + FRAC_BITS + 1 : 29) + 1;
   localparam int LO_W   = OFF_W + 21;
   localparam int HI_W   = OFF_W + 20;
   localparam int SUM_W  = OFF_W + 41;
   localparam int SMAX   = SUM_W - NORM_BITS - 1;
   localparam int S_W    = $clog2(SMAX + 1);

   logic [5:0] valid_ff;

   // stage 1: offsets from the reference pixel
   logic signed [OFF_W-1:0] ox_ff, ox_in, oy_ff, oy_in;

   always_comb begin
      ox_in = OFF_W'($signed({1'b0, pixel_x, {FRAC_BITS{1'b0}}})) - OFF_W'(cfg.ref_pixel_x);
      oy_in = OFF_W'($signed({1'b0, pixel_y, {FRAC_BITS{1'b0}}})) - OFF_W'(cfg.ref_pixel_y);
   end

   // stage 2: partial products, matrix terms split into high and low halves
   logic signed [LO_W-1:0] lxx_ff, lxx_in, lxy_ff, lxy_in, lyx_ff, lyx_in, lyy_ff, lyy_in;
   logic signed [HI_W-1:0] hxx_ff, hxx_in, hxy_ff, hxy_in, hyx_ff, hyx_in, hyy_ff, hyy_in;

   always_comb begin
      lxx_in = $signed({1'b0, cfg.scale_xx[19:0]}) * ox_ff;
      lxy_in = $signed({1'b0, cfg.scale_xy[19:0]}) * oy_ff;
      lyx_in = $signed({1'b0, cfg.scale_yx[19:0]}) * ox_ff;
      lyy_in = $signed({1'b0, cfg.scale_yy[19:0]}) * oy_ff;
      hxx_in = $signed(cfg.scale_xx[39:20]) * ox_ff;
      hxy_in = $signed(cfg.scale_xy[39:20]) * oy_ff;
      hyx_in = $signed(cfg.scale_yx[39:20]) * ox_ff;
      hyy_in = $signed(cfg.scale_yy[39:20]) * oy_ff;
   end

   // stage 3: tangent-plane east and north
   logic signed [SUM_W-1:0] east_ff, east_in, north_ff, north_in;

   always_comb begin
      east_in  = (SUM_W'(hxx_ff) <<< 20) + SUM_W'(lxx_ff)
               + (SUM_W'(hxy_ff) <<< 20) + SUM_W'(lxy_ff);
      north_in = (SUM_W'(hyx_ff) <<< 20) + SUM_W'(lyx_ff)
               + (SUM_W'(hyy_ff) <<< 20) + SUM_W'(lyy_ff);
   end

   // stage 4: small-offset magnitudes and normalizing shift
   logic signed [SUM_W-1:0] east4_ff, north4_ff;
   logic                    ne_ff, ne_in, nn_ff, nn_in;
   logic [17:0]             me_ff, me_in, mn_ff, mn_in;
   logic [S_W-1:0]          s_ff, s_in;

   always_comb begin
      logic signed [SUM_W-1:0] te, tn;
      ne_in = (east_ff  > -$signed(SUM_W'(NEAR_LIMIT))) && (east_ff  < $signed(SUM_W'(NEAR_LIMIT)));
      nn_in = (north_ff > -$signed(SUM_W'(NEAR_LIMIT))) && (north_ff < $signed(SUM_W'(NEAR_LIMIT)));
      me_in = east_ff[SUM_W-1]  ? 18'(-east_ff)  : 18'(east_ff);
      mn_in = north_ff[SUM_W-1] ? 18'(-north_ff) : 18'(north_ff);
      s_in  = S_W'(SMAX);
      for (int k = SMAX; k >= 1; k--) begin
         te = east_ff  >>> (NORM_BITS + k);
         tn = north_ff >>> (NORM_BITS + k);
         if ((te == '0 || te == '1) && (tn == '0 || tn == '1)) begin
            s_in = S_W'(k);
         end
      end
   end

   // stage 5: offset radius test and scaled direction terms
   logic                   near_ff, near_in;
   logic signed [XY_W-1:0] ke_ff, ke_in, ve_ff, ve_in, vn_ff, vn_in;

   always_comb begin
      near_in = ne_ff && nn_ff &&
                ((38'(me_ff) * 38'(me_ff) + 38'(mn_ff) * 38'(mn_ff)) < NEAR_SQ);
      ke_in   = $signed(DEG_PER_RAD >> s_ff);
      ve_in   = XY_W'(east4_ff  >>> s_ff);
      vn_in   = XY_W'(north4_ff >>> s_ff);
   end

   // stage 6: fold the reference declination into one half turn
   logic signed [ANG_W-1:0] d0;
   logic signed [XY_W-1:0]  ke6_ff, ke6_in, vn6_ff, vn6_in, ve6_ff;
   logic signed [ANG_W-1:0] d0_ff, d0_in;
   logic                    near6_ff;

   always_comb begin
      d0     = ANG_W'(cfg.ref_dec);
      ke6_in = ke_ff;
      vn6_in = vn_ff;
      d0_in  = d0;
      if (d0 > QUARTER || d0 < -QUARTER) begin
         ke6_in = -ke_ff;
         vn6_in = -vn_ff;
         d0_in  = d0[ANG_W-1] ? d0 + HALF : d0 - HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
      if (en) begin
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         lxx_ff    <= lxx_in;
         lxy_ff    <= lxy_in;
         lyx_ff    <= lyx_in;
         lyy_ff    <= lyy_in;
         hxx_ff    <= hxx_in;
         hxy_ff    <= hxy_in;
         hyx_ff    <= hyx_in;
         hyy_ff    <= hyy_in;
         east_ff   <= east_in;
         north_ff  <= north_in;
         east4_ff  <= east_ff;
         north4_ff <= north_ff;
         ne_ff     <= ne_in;
         nn_ff     <= nn_in;
         me_ff     <= me_in;
         mn_ff     <= mn_in;
         s_ff      <= s_in;
         near_ff   <= near_in;
         ke_ff     <= ke_in;
         ve_ff     <= ve_in;
         vn_ff     <= vn_in;
         ke6_ff    <= ke6_in;
         vn6_ff    <= vn6_in;
         ve6_ff    <= ve_ff;
         d0_ff     <= d0_in;
         near6_ff  <= near_ff;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_ke    = ke6_ff;
   assign out_vn    = vn6_ff;
   assign out_ve    = ve6_ff;
   assign out_d0    = d0_ff;
   assign out_near  = near6_ff;

endmodule

`default_nettype wire

>>> sv/pixel_to_sky_tan_projection_top.sv
// throughput one pixel per cycle unless a stalled result holds the pipeline; three
// chains of CORDIC cells, each cell one register stage
// a stalled result halts every stage while the last cell is valid, else bubbles move
// synchronous reset clears all valid flags and the configuration registers
`default_nettype none

module pixel_to_sky_tan_projection_top #(
   parameter int  PIXEL_BITS   = tpc_pkg::PIXEL_BITS_DEF,
   parameter int  CORDIC_STEPS = tpc_pkg::CORDIC_STEPS_DEF,
   localparam int REQ_W        = ((2 * PIXEL_BITS + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration writes
   input  wire logic                              csr_we,
   input  wire logic [tpc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [tpc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // pixel stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [REQ_W-1:0]                  req_tdata,  // pixel_x, pixel_y
   // sky coordinate stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [63:0]                            rsp_tdata,  // right_ascension, declination
   output logic                                   rsp_tuser   // at_reference
);
   import tpc_pkg::*;

   localparam int CS = CORDIC_STEPS;

   // configuration registers
   tpc_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_REF_PIXEL_X: cfg_ff.ref_pixel_x <= csr_wdata[28:0];
            REG_REF_PIXEL_Y: cfg_ff.ref_pixel_y <= csr_wdata[28:0];
            REG_REF_RA:      cfg_ff.ref_ra      <= csr_wdata[31:0];
            REG_REF_DEC:     cfg_ff.ref_dec     <= csr_wdata[31:0];
            REG_SCALE_XX:    cfg_ff.scale_xx    <= csr_wdata;
            REG_SCALE_XY:    cfg_ff.scale_xy    <= csr_wdata;
            REG_SCALE_YX:    cfg_ff.scale_yx    <= csr_wdata;
            REG_SCALE_YY:    cfg_ff.scale_yy    <= csr_wdata;
         endcase
      end
   end

   // pipeline advance: blocked only by a full, stalled output register with a valid last cell
   logic last_valid;
   logic out_free;
   logic adv;

   assign out_free   = !rsp_tvalid || rsp_tready;
   assign adv        = out_free || !last_valid;
   assign req_tready = adv;

   // front end
   logic                    rv   [CS+1];
   logic signed [XY_W-1:0]  rx   [CS+1];
   logic signed [XY_W-1:0]  ry   [CS+1];
   logic signed [ANG_W-1:0] rz   [CS+1];
   logic [XY_W:0]           rs   [CS+1];
   logic signed [XY_W-1:0]  f_ve;
   logic                    f_near;

   tpc_front #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .pixel_x   (req_tdata[PIXEL_BITS-1:0]),
      .pixel_y   (req_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
      .out_valid (rv[0]),
      .out_ke    (rx[0]),
      .out_vn    (ry[0]),
      .out_ve    (f_ve),
      .out_d0    (rz[0]),
      .out_near  (f_near)
   );

   assign rs[0] = {f_ve, f_near};

   // rotation by the reference declination
   for (genvar i = 0; i < CS; i++) begin : g_rot
      tpc_cordic_cell #(
         .STEP   (i),
         .MODE   (CELL_ROTATE),
         .SIDE_W (XY_W + 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (rv[i]),
         .in_x      (rx[i]),
         .in_y      (ry[i]),
         .in_z      (rz[i]),
         .in_side   (rs[i]),
         .out_valid (rv[i+1]),
         .out_x     (rx[i+1]),
         .out_y     (ry[i+1]),
         .out_z     (rz[i+1]),
         .out_side  (rs[i+1])
      );
   end

   // gain correction, split into two 32-bit products
   logic                   m1_valid_ff, m2_valid_ff;
   logic signed [64:0]     m_phi_ff, m_phi_in;
   logic [63:0]            m_plo_ff, m_plo_in;
   logic signed [XY_W-1:0] m1_vn_ff, m1_ve_ff, m2_vn_ff, m2_ve_ff;
   logic                   m1_near_ff, m2_near_ff;
   logic signed [XY_W-1:0] xc_ff, xc_in;

   always_comb begin
      m_phi_in = $signed(rx[CS][63:32]) * $signed({1'b0, INV_GAIN});
      m_plo_in = 64'(rx[CS][31:0]) * 64'(INV_GAIN);
      xc_in    = XY_W'(m_phi_ff) + $signed(m_plo_ff >> 32);
   end

   // first vectoring setup: fold x into the right half plane
   logic signed [XY_W-1:0]  ax [CS+1];
   logic signed [XY_W-1:0]  ay [CS+1];
   logic signed [ANG_W-1:0] az [CS+1];
   logic [XY_W+1:0]         as_side [CS+1];
   logic                    av [CS+1];
   logic signed [XY_W-1:0]  p1_x_in, p1_y_in;
   logic signed [ANG_W-1:0] p1_z_in;
   logic                    p1_zero;

   always_comb begin
      p1_zero = (xc_ff == '0) && (m2_ve_ff == '0);
      if (xc_ff[XY_W-1]) begin
         p1_x_in = -xc_ff;
         p1_y_in = -m2_ve_ff;
         p1_z_in = HALF;
      end else begin
         p1_x_in = xc_ff;
         p1_y_in = m2_ve_ff;
         p1_z_in = '0;
      end
   end

   logic                    p1_valid_ff;
   logic signed [XY_W-1:0]  p1_x_ff, p1_y_ff;
   logic signed [ANG_W-1:0] p1_z_ff;
   logic [XY_W+1:0]         p1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= rv[CS];
         m2_valid_ff <= m1_valid_ff;
         p1_valid_ff <= m2_valid_ff;
      end
      if (adv) begin
         m_phi_ff   <= m_phi_in;
         m_plo_ff   <= m_plo_in;
         m1_vn_ff   <= ry[CS];
         m1_ve_ff   <= rs[CS][XY_W:1];
         m1_near_ff <= rs[CS][0];
         xc_ff      <= xc_in;
         m2_vn_ff   <= m1_vn_ff;
         m2_ve_ff   <= m1_ve_ff;
         m2_near_ff <= m1_near_ff;
         p1_x_ff    <= p1_x_in;
         p1_y_ff    <= p1_y_in;
         p1_z_ff    <= p1_z_in;
         p1_side_ff <= {m2_vn_ff, m2_near_ff, p1_zero};
      end
   end

   assign av[0]      = p1_valid_ff;
   assign ax[0]      = p1_x_ff;
   assign ay[0]      = p1_y_ff;
   assign az[0]      = p1_z_ff;
   assign as_side[0] = p1_side_ff;

   // vectoring for the right ascension offset
   for (genvar i = 0; i < CS; i++) begin : g_vec_ra
      tpc_cordic_cell #(
         .STEP   (i),
         .MODE   (CELL_VECTOR),
         .SIDE_W (XY_W + 2)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (av[i]),
         .in_x      (ax[i]),
         .in_y      (ay[i]),
         .in_z      (az[i]),
         .in_side   (as_side[i]),
         .out_valid (av[i+1]),
         .out_x     (ax[i+1]),
         .out_y     (ay[i+1]),
         .out_z     (az[i+1]),
         .out_side  (as_side[i+1])
      );
   end

   // second vectoring setup: declination from horizontal radius and height
   logic signed [XY_W-1:0]  bx [CS+1];
   logic signed [XY_W-1:0]  by [CS+1];
   logic signed [ANG_W-1:0] bz [CS+1];
   logic [ANG_W+1:0]        bs [CS+1];
   logic                    bv [CS+1];
   logic signed [XY_W-1:0]  h, vn2;
   logic signed [ANG_W-1:0] ra_ang;
   logic signed [XY_W-1:0]  p2_x_in, p2_y_in;
   logic signed [ANG_W-1:0] p2_z_in;
   logic                    p2_zero;

   always_comb begin
      h       = ax[CS];
      vn2     = as_side[CS][XY_W+1:2];
      ra_ang  = as_side[CS][0] ? '0 : az[CS];
      p2_zero = (h == '0) && (vn2 == '0);
      if (h[XY_W-1]) begin
         p2_x_in = -h;
         p2_y_in = -vn2;
         p2_z_in = HALF;
      end else begin
         p2_x_in = h;
         p2_y_in = vn2;
         p2_z_in = '0;
      end
   end

   logic                    p2_valid_ff;
   logic signed [XY_W-1:0]  p2_x_ff, p2_y_ff;
   logic signed [ANG_W-1:0] p2_z_ff;
   logic [ANG_W+1:0]        p2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= av[CS];
      end
      if (adv) begin
         p2_x_ff    <= p2_x_in;
         p2_y_ff    <= p2_y_in;
         p2_z_ff    <= p2_z_in;
         p2_side_ff <= {ra_ang, as_side[CS][1], p2_zero};
      end
   end

   assign bv[0] = p2_valid_ff;
   assign bx[0] = p2_x_ff;
   assign by[0] = p2_y_ff;
   assign bz[0] = p2_z_ff;
   assign bs[0] = p2_side_ff;

   // vectoring for the declination
   for (genvar i = 0; i < CS; i++) begin : g_vec_dec
      tpc_cordic_cell #(
         .STEP   (i),
         .MODE   (CELL_VECTOR),
         .SIDE_W (ANG_W + 2)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (bv[i]),
         .in_x      (bx[i]),
         .in_y      (by[i]),
         .in_z      (bz[i]),
         .in_side   (bs[i]),
         .out_valid (bv[i+1]),
         .out_x     (bx[i+1]),
         .out_y     (by[i+1]),
         .out_z     (bz[i+1]),
         .out_side  (bs[i+1])
      );
   end

   assign last_valid = bv[CS];

   // final clamp, right ascension wrap and reference bypass
   logic signed [ANG_W-1:0] dec_raw, dec_clamp;
   logic [63:0]             rsp_data_in;
   logic                    rsp_user_in;
   logic                    rsp_valid_ff;
   logic [63:0]             rsp_data_ff;
   logic                    rsp_user_ff;

   always_comb begin
      dec_raw = bs[CS][0] ? '0 : bz[CS];
      priority if (dec_raw > QUARTER) begin
         dec_clamp = QUARTER;
      end else if (dec_raw < -QUARTER) begin
         dec_clamp = -QUARTER;
      end else begin
         dec_clamp = dec_raw;
      end
      rsp_user_in = bs[CS][1];
      if (bs[CS][1]) begin
         rsp_data_in = {cfg_ff.ref_dec, cfg_ff.ref_ra};
      end else begin
         // low 32 bits of the right ascension offset sit just above the two flags
         rsp_data_in = {dec_clamp[31:0], cfg_ff.ref_ra + bs[CS][2 +: 32]};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= last_valid;
      end
      if (out_free) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

>>> sv/tpc_checker.sv
// port-level checks on the projection pipeline, bound to the top level;
// depends on pixel_to_sky_tan_projection_top
`default_nettype none

module tpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // computed declination stays within a quarter turn
   a_dec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         ($signed(rsp_tdata[63:32]) <= 32'sd1073741824) &&
         ($signed(rsp_tdata[63:32]) >= -32'sd1073741824))
      else $error("declination out of range");

   // reset empties the pipeline and the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind pixel_to_sky_tan_projection_top tpc_checker u_tpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> test/tb_pixel_to_sky_tan_projection_top.sv
// self-checking testbench for the pixel to sky tangent-plane deprojection block
// depends on tpc_pkg and pixel_to_sky_tan_projection_top; predicts each result in
// fixed point and compares every transfer on the sky coordinate stream
`default_nettype none

module tb_pixel_to_sky_tan_projection_top;
   import tpc_pkg::*;

   localparam int  PIPE_DEPTH  = 3 * CORDIC_STEPS_DEF + 11;
   localparam int  CYCLE_LIMIT = 600000;
   localparam longint NEAR_R   = 258037;
   localparam longint QTR      = 64'sd1073741824;
   localparam longint HLF      = 64'sd2147483648;
   localparam longint GAIN_INV = 64'sd2608131496;

   localparam logic [31:0] ATAN_STEP [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct {
      logic [31:0] ra;
      logic [31:0] dec;
      logic        at_ref;
   } sky_point_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;   // pixel_x, pixel_y
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [63:0]            rsp_tdata;   // right_ascension, declination
   logic                   rsp_tuser;   // at_reference

   // local copy of the configuration
   tpc_cfg_type            cfg;
   sky_point_type          sky_expected[$];
   int                     mismatch_count;
   int                     cycle_count = 0;
   int                     src_idle_pct;
   int                     snk_stall_pct;

   pixel_to_sky_tan_projection_top DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // clock and run limit
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // vectoring pass, returns the angle and leaves the magnitude in mag
   function automatic longint vector_angle(input longint x, input longint y,
                                           output longint mag);
      longint base, z, sx, sy, a;
      base = 0;
      z    = 0;
      mag  = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x    = -x;
         y    = -y;
         base = HLF;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         a  = ATAN_STEP[i];
         sx = x >>> i;
         sy = y >>> i;
         if (y < 0) begin
            x += sy; x -= 2 * sy; y += sx; z -= a;
         end else begin
            x += sy; y -= sx; z += a;
         end
      end
      mag = x;
      return base + z;
   endfunction

   function automatic bit in_norm(input logic signed [127:0] v);
      return v >= -(128'sd1 <<< 57) && v < (128'sd1 <<< 57);
   endfunction

   // deprojection of one pixel under the current configuration
   function automatic sky_point_type project_pixel(input logic [15:0] px,
                                                   input logic [15:0] py);
      logic signed [127:0] ox, oy, east, north, kw, wp;
      longint              ke, ve, vn, d0, xc, h, tmp, ra_a, dec_a, sx, sy, a, ang;
      int                  s;
      sky_point_type       r;
      ox    = $signed({1'b0, px, 12'b0}) - cfg.ref_pixel_x;
      oy    = $signed({1'b0, py, 12'b0}) - cfg.ref_pixel_y;
      east  = cfg.scale_xx * ox + cfg.scale_xy * oy;
      north = cfg.scale_yx * ox + cfg.scale_yy * oy;
      // offset below one bit of resolution
      if (east > -NEAR_R && east < NEAR_R && north > -NEAR_R && north < NEAR_R &&
          east * east + north * north < NEAR_R * NEAR_R) begin
         r.ra     = cfg.ref_ra;
         r.dec    = cfg.ref_dec;
         r.at_ref = 1'b1;
         return r;
      end
      kw = $signed({1'b0, DEG_PER_RAD});
      s  = 1;
      while (s < 63 && !(in_norm(east >>> s) && in_norm(north >>> s) && in_norm(kw >>> s)))
         s++;
      wp = kw >>> s;    ke = wp[63:0];
      wp = east >>> s;  ve = wp[63:0];
      wp = north >>> s; vn = wp[63:0];
      d0 = cfg.ref_dec;
      // reference declination past the pole
      if (d0 > QTR || d0 < -QTR) begin
         ke = -ke;
         vn = -vn;
         d0 = d0 > 0 ? d0 - HLF : d0 + HLF;
      end
      ang = d0;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         a  = ATAN_STEP[i];
         sx = ke >>> i;
         sy = vn >>> i;
         if (ang >= 0) begin
            ke -= sy; vn += sx; ang -= a;
         end else begin
            ke += sy; vn -= sx; ang += a;
         end
      end
      wp    = ke;
      wp    = (wp * GAIN_INV) >>> 32;
      xc    = wp[63:0];
      ra_a  = vector_angle(xc, ve, h);
      dec_a = vector_angle(h, vn, tmp);
      if (dec_a > QTR)  dec_a = QTR;
      if (dec_a < -QTR) dec_a = -QTR;
      r.ra     = cfg.ref_ra + ra_a[31:0];
      r.dec    = dec_a[31:0];
      r.at_ref = 1'b0;
      return r;
   endfunction

   // result checker, handshake sampled between edges
   always @(negedge clock) begin
      sky_point_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sky_expected.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            e = sky_expected.pop_front();
            if (rsp_tdata[31:0] !== e.ra)
               report_mismatch($sformatf("right_ascension %h, expected %h",
                                         rsp_tdata[31:0], e.ra));
            if (rsp_tdata[63:32] !== e.dec)
               report_mismatch($sformatf("declination %h, expected %h",
                                         rsp_tdata[63:32], e.dec));
            if (rsp_tuser !== e.at_ref)
               report_mismatch($sformatf("at_reference %b, expected %b", rsp_tuser, e.at_ref));
         end
      end
   end

   // one pixel transfer, called at a rising edge
   task automatic send_pixel(input logic [15:0] px, input logic [15:0] py);
      bit taken;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      sky_expected.push_back(project_pixel(px, py));
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   // wait for every expected result, then let the pipe empty
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (sky_expected.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [39:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         REG_REF_PIXEL_X: cfg.ref_pixel_x = val[28:0];
         REG_REF_PIXEL_Y: cfg.ref_pixel_y = val[28:0];
         REG_REF_RA:      cfg.ref_ra      = val[31:0];
         REG_REF_DEC:     cfg.ref_dec     = val[31:0];
         REG_SCALE_XX:    cfg.scale_xx    = val;
         REG_SCALE_XY:    cfg.scale_xy    = val;
         REG_SCALE_YX:    cfg.scale_yx    = val;
         default:         cfg.scale_yy    = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(input logic [28:0] rx, input logic [28:0] ry,
                            input logic [31:0] ra, input logic [31:0] dec,
                            input logic [39:0] sxx, input logic [39:0] sxy,
                            input logic [39:0] syx, input logic [39:0] syy);
      write_reg(REG_REF_PIXEL_X, {{11{rx[28]}}, rx});
      write_reg(REG_REF_PIXEL_Y, {{11{ry[28]}}, ry});
      write_reg(REG_REF_RA, {8'h0, ra});
      write_reg(REG_REF_DEC, {{8{dec[31]}}, dec});
      write_reg(REG_SCALE_XX, sxx);
      write_reg(REG_SCALE_XY, sxy);
      write_reg(REG_SCALE_YX, syx);
      write_reg(REG_SCALE_YY, syy);
   endtask

   function automatic logic [39:0] rand_scale();
      logic signed [39:0] v;
      v = 40'({$urandom, $urandom});
      return v >>> $urandom_range(0, 34);
   endfunction

   // all-zero matrix after reset: every pixel maps to the reference
   task automatic test_reset_state();
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(16'h1234, 16'hABCD);
      drain_pipe();
   endtask

   // field extremes, reference hit, poles and the declination wrap
   task automatic test_directed();
      write_all(29'd4096000, 29'd4096000, 32'h4000_0000, 32'h1000_0000,
                40'sd305419896, 40'sd0, 40'sd0, 40'sd305419896);
      send_pixel(16'd1000, 16'd1000);
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'h5555, 16'hAAAA);
      drain_pipe();
      // extreme matrix and reference pixel, reference declination at the poles
      write_all(29'h0FFF_FFFF, 29'h1000_0000, 32'hFFFF_FFFF, 32'h4000_0000,
                40'h7F_FFFF_FFFF, 40'h80_0000_0000, 40'h80_0000_0000, 40'h7F_FFFF_FFFF);
      send_pixel(16'h0000, 16'hFFFF);
      send_pixel(16'hFFFF, 16'h0000);
      drain_pipe();
      write_reg(REG_REF_DEC, {8'hFF, 32'hC000_0000});
      send_pixel(16'h8000, 16'h7FFF);
      // declination past a quarter turn in both directions
      drain_pipe();
      write_reg(REG_REF_DEC, {8'hFF, 32'h8000_0000});
      send_pixel(16'h0001, 16'hFFFE);
      drain_pipe();
      write_reg(REG_REF_DEC, {8'h00, 32'h7FFF_FFFF});
      send_pixel(16'hFFFE, 16'h0001);
      drain_pipe();
      // no east component at the pole: vectoring operands vanish
      write_all(29'd0, 29'd0, 32'h8000_0000, 32'h4000_0000,
                40'sd0, 40'sd0, 40'sd1000000, 40'sd0);
      send_pixel(16'd1, 16'd0);
      send_pixel(16'd0, 16'd1);
      send_pixel(16'd1, 16'd1);
      drain_pipe();
   endtask

   // random configurations under one idling pattern
   task automatic test_random(input int items);
      logic [15:0] px, py, cx, cy;
      int          done;
      done = 0;
      while (done < items) begin
         cx = 16'($urandom);
         cy = 16'($urandom);
         write_all($urandom_range(0, 3) == 0 ? 29'($urandom) : {1'b0, cx, 12'b0} +
                   29'($urandom_range(0, 8191)) - 29'd4096,
                   $urandom_range(0, 3) == 0 ? 29'($urandom) : {1'b0, cy, 12'b0},
                   $urandom, $urandom, rand_scale(), rand_scale(), rand_scale(), rand_scale());
         for (int k = 0; k < 60 && done < items; k++) begin
            case ($urandom_range(0, 3))
               0: begin px = 16'($urandom); py = 16'($urandom); end
               1: begin px = cx; py = cy; end
               default: begin
                  px = cx + 16'($urandom_range(0, 6)) - 16'd3;
                  py = cy + 16'($urandom_range(0, 6)) - 16'd3;
               end
            endcase
            send_pixel(px, py);
            done++;
         end
         drain_pipe();
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      cfg            = '0;
      mismatch_count = 0;
      src_idle_pct   = 0;
      snk_stall_pct  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_idle_pct  = 18;
      snk_stall_pct = 70;
      test_reset_state();
      test_directed();
      test_random(580);
      src_idle_pct  = 70;
      snk_stall_pct = 18;
      test_random(580);
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      test_random(580);

      drain_pipe();
      if (sky_expected.size() != 0)
         report_mismatch("expected results left over");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
sv/tpc_pkg.sv
sv/tpc_cordic_cell.sv
sv/tpc_front.sv
sv/pixel_to_sky_tan_projection_top.sv
sv/tpc_checker.sv
test/tb_pixel_to_sky_tan_projection_top.sv
